// ----- sv/lsg_pkg.sv -----
package lsg_pkg;

	// Grid defaults
	localparam int GRID_WIDTH_DEF = 52;
	localparam int GRID_HEIGHT_DEF = 39;

	// Field widths
	localparam int COORD_W = 6;
	localparam int BASE_W = 11;
	localparam int RADIUS_W = 8;
	localparam int STRENGTH_W = 13;
	localparam int GAIN_W = 8;
	localparam int GAIN_MAX = 255;

	// Offsets reach -64..63, so a squared distance fits in 14 bits
	localparam int ROOT_W = 7;
	localparam int SQ_W = 2 * ROOT_W;
	localparam int SQ_STEPS_PER_STAGE = 4;
	localparam int SQ_STAGES = (ROOT_W + SQ_STEPS_PER_STAGE - 1) / SQ_STEPS_PER_STAGE;

	// span * |strength| <= 255 * 4096; the quotient never exceeds |strength|
	localparam int PROD_W = 20;
	localparam int QUO_W = STRENGTH_W;
	localparam int DIV_STEPS_PER_STAGE = 4;
	localparam int DIV_STAGES = (QUO_W + DIV_STEPS_PER_STAGE - 1) / DIV_STEPS_PER_STAGE;

endpackage

// ----- sv/radial_lens_shading_gain_core.sv -----
// Throughput: one item per cycle while the output is not stalled; every stage moves on its own enable, so bubbles fill.
// Depth is set by the 2-stage square-root unit and the 4-stage divider, plus
// the offset, multiply and output stages.
// Reset clears only the stage valid bits; data registers are not reset.
module radial_lens_shading_gain_core #(
	parameter int GRID_WIDTH = lsg_pkg::GRID_WIDTH_DEF,
	parameter int GRID_HEIGHT = lsg_pkg::GRID_HEIGHT_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cell_valid,
	output logic                                   cell_ready,
	input  logic [lsg_pkg::COORD_W-1:0]            cell_x,
	input  logic [lsg_pkg::COORD_W-1:0]            cell_y,
	input  logic signed [lsg_pkg::BASE_W-1:0]      channel_base,
	input  logic [lsg_pkg::RADIUS_W-1:0]           falloff_radius,
	input  logic signed [lsg_pkg::STRENGTH_W-1:0]  boost_strength,
	output logic                                   gain_valid,
	input  logic                                   gain_ready,
	output logic [lsg_pkg::GAIN_W-1:0]             gain_value
);

	localparam int SQ_FIRST = 2;
	localparam int SQ_LAST = 1 + lsg_pkg::SQ_STAGES;
	localparam int MS = SQ_LAST + 1;
	localparam int DIV_FIRST = MS + 1;
	localparam int DIV_LAST = MS + lsg_pkg::DIV_STAGES;
	localparam int NS = DIV_LAST + 1;
	localparam int OFS_W = lsg_pkg::COORD_W + 2;
	localparam int SUM_W = lsg_pkg::QUO_W + 2;

	localparam logic [OFS_W-1:0] CX = OFS_W'(GRID_WIDTH / 2);
	localparam logic [OFS_W-1:0] CY = OFS_W'(GRID_HEIGHT / 2);
	localparam logic signed [SUM_W-1:0] GMAX = SUM_W'(lsg_pkg::GAIN_MAX);

	typedef struct packed {
		logic signed [lsg_pkg::BASE_W-1:0] base;
		logic [lsg_pkg::RADIUS_W-1:0]      radius;
		logic [lsg_pkg::STRENGTH_W-1:0]    smag;
		logic                              sneg;
	} side_t;

	logic [NS:1] vld_s;
	logic [NS:1] en;
	side_t side_s [1:NS-1];

	logic signed [OFS_W-1:0]   dx, dy;
	logic signed [2*OFS_W-1:0] dx2, dy2;
	logic [lsg_pkg::SQ_W-1:0]  sq_s1;
	logic [lsg_pkg::STRENGTH_W-1:0] smag_d;

	logic [lsg_pkg::ROOT_W-1:0]   root;
	logic [lsg_pkg::RADIUS_W-1:0] span_d;
	logic [lsg_pkg::PROD_W-1:0]   prod_s4;

	logic [lsg_pkg::QUO_W-1:0]    quo;
	logic signed [lsg_pkg::QUO_W:0] boost_d;
	logic signed [SUM_W-1:0]      sum_d;
	logic [lsg_pkg::GAIN_W-1:0]   clamp_d;
	logic [lsg_pkg::GAIN_W-1:0]   gain_s9;

	// Let a stage advance when it is empty or the next one advances
	always_comb begin
		en[NS] = !vld_s[NS] || gain_ready;
		for (int i = NS - 1; i >= 1; i--) begin
			en[i] = !vld_s[i] || en[i+1];
		end
	end

	assign cell_ready = en[1];

	// Move valid bits along with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[1]) begin
				vld_s[1] <= cell_valid;
			end
			for (int i = 2; i <= NS; i++) begin
				if (en[i]) begin
					vld_s[i] <= vld_s[i-1];
				end
			end
		end
	end

	// Stage 1: offsets from the centre cell, squared distance, strength magnitude
	assign dx = $signed({2'b00, cell_x}) - $signed(CX);
	assign dy = $signed({2'b00, cell_y}) - $signed(CY);
	assign dx2 = dx * dx;
	assign dy2 = dy * dy;
	assign smag_d = boost_strength[lsg_pkg::STRENGTH_W-1]
		? lsg_pkg::STRENGTH_W'(-boost_strength) : boost_strength;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			sq_s1 <= lsg_pkg::SQ_W'(dx2 + dy2);
			side_s[1] <= '{base: channel_base, radius: falloff_radius,
				smag: smag_d, sneg: boost_strength[lsg_pkg::STRENGTH_W-1]};
		end
		for (int i = 2; i < NS; i++) begin
			if (en[i]) begin
				side_s[i] <= side_s[i-1];
			end
		end
	end

	// Distance: floor of the square root
	lsg_isqrt_pipe u_isqrt (
		.clk      (clk),
		.en       (en[SQ_LAST:SQ_FIRST]),
		.radicand (sq_s1),
		.root     (root)
	);

	// Multiply stage: clipped span times strength magnitude
	assign span_d = (side_s[SQ_LAST].radius > {1'b0, root})
		? side_s[SQ_LAST].radius - {1'b0, root} : '0;

	always_ff @(posedge clk) begin
		if (en[MS]) begin
			prod_s4 <= lsg_pkg::PROD_W'(span_d * side_s[SQ_LAST].smag);
		end
	end

	// Divide the magnitude by the radius
	lsg_div_pipe u_div (
		.clk      (clk),
		.en       (en[DIV_LAST:DIV_FIRST]),
		.dividend (prod_s4),
		.divisor  (side_s[MS].radius),
		.quotient (quo)
	);

	// Output stage: restore sign, add base, clamp or pass the raw base byte
	assign boost_d = side_s[DIV_LAST].sneg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
	assign sum_d = side_s[DIV_LAST].base + boost_d;

	always_comb begin
		if (sum_d[SUM_W-1]) begin
			clamp_d = '0;
		end else if (sum_d > GMAX) begin
			clamp_d = lsg_pkg::GAIN_W'(lsg_pkg::GAIN_MAX);
		end else begin
			clamp_d = sum_d[lsg_pkg::GAIN_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[NS]) begin
			gain_s9 <= (side_s[DIV_LAST].radius == '0)
				? side_s[DIV_LAST].base[lsg_pkg::GAIN_W-1:0] : clamp_d;
		end
	end

	assign gain_valid = vld_s[NS];
	assign gain_value = gain_s9;

	// An empty output register must leave the whole pipe open
	a_open_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!gain_valid |-> cell_ready)
		else $error("input blocked while output register is empty");

	// A taken result frees every stage
	a_open_when_taken: assert property (@(posedge clk) disable iff (!arst_n)
		gain_ready |-> cell_ready)
		else $error("input blocked while result is taken");

	// A stalled multiply stage keeps its item
	a_mult_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[MS] && !en[MS]) |=> (vld_s[MS] && $stable(prod_s4)))
		else $error("multiply stage lost an item under stall");

endmodule

// ----- sv/lsg_isqrt_pipe.sv -----
module lsg_isqrt_pipe (
	input  logic                                clk,
	input  logic [lsg_pkg::SQ_STAGES-1:0]       en,
	input  logic [lsg_pkg::SQ_W-1:0]            radicand,
	output logic [lsg_pkg::ROOT_W-1:0]          root
);

	localparam int RW = lsg_pkg::ROOT_W;
	localparam int NW = 2 * RW;
	localparam int ST = lsg_pkg::SQ_STAGES;
	localparam int SPS = lsg_pkg::SQ_STEPS_PER_STAGE;

	logic [NW-1:0] rad_s [ST];
	logic [RW:0]   rem_s [ST];
	logic [RW-1:0] root_s [ST];

	logic [NW-1:0] rad_in [ST];
	logic [RW:0]   rem_in [ST];
	logic [RW-1:0] root_in [ST];

	logic [NW-1:0] rad_d [ST];
	logic [RW:0]   rem_d [ST];
	logic [RW-1:0] root_d [ST];

	// Feed each stage from the one before it
	always_comb begin
		rad_in[0] = NW'(radicand);
		rem_in[0] = '0;
		root_in[0] = '0;
		for (int k = 1; k < ST; k++) begin
			rad_in[k] = rad_s[k-1];
			rem_in[k] = rem_s[k-1];
			root_in[k] = root_s[k-1];
		end
	end

	// Resolve a few root bits per stage, two radicand bits per step
	always_comb begin
		logic [NW-1:0] n;
		logic [RW:0]   r;
		logic [RW-1:0] q;
		logic [RW+2:0] t;
		logic [RW+2:0] trial;
		for (int k = 0; k < ST; k++) begin
			n = rad_in[k];
			r = rem_in[k];
			q = root_in[k];
			for (int j = 0; j < SPS; j++) begin
				if (k * SPS + j < RW) begin
					t = {r, n[NW-1 -: 2]};
					trial = {1'b0, q, 2'b01};
					if (t >= trial) begin
						t = t - trial;
						q = {q[RW-2:0], 1'b1};
					end else begin
						q = {q[RW-2:0], 1'b0};
					end
					r = t[RW:0];
					n = {n[NW-3:0], 2'b00};
				end
			end
			rad_d[k] = n;
			rem_d[k] = r;
			root_d[k] = q;
		end
	end

	// Advance each stage when its enable is high
	always_ff @(posedge clk) begin
		for (int k = 0; k < ST; k++) begin
			if (en[k]) begin
				rad_s[k] <= rad_d[k];
				rem_s[k] <= rem_d[k];
				root_s[k] <= root_d[k];
			end
		end
	end

	assign root = root_s[ST-1];

endmodule

// ----- sv/lsg_div_pipe.sv -----
module lsg_div_pipe (
	input  logic                                clk,
	input  logic [lsg_pkg::DIV_STAGES-1:0]      en,
	input  logic [lsg_pkg::PROD_W-1:0]          dividend,
	input  logic [lsg_pkg::RADIUS_W-1:0]        divisor,
	output logic [lsg_pkg::QUO_W-1:0]           quotient
);

	localparam int QW = lsg_pkg::QUO_W;
	localparam int DW = lsg_pkg::RADIUS_W;
	localparam int PW = lsg_pkg::PROD_W;
	localparam int ST = lsg_pkg::DIV_STAGES;
	localparam int SPS = lsg_pkg::DIV_STEPS_PER_STAGE;

	logic [QW-1:0] num_s [ST];
	logic [DW-1:0] rem_s [ST];
	logic [QW-1:0] quo_s [ST];
	logic [DW-1:0] dvs_s [ST];

	logic [QW-1:0] num_in [ST];
	logic [DW-1:0] rem_in [ST];
	logic [QW-1:0] quo_in [ST];
	logic [DW-1:0] dvs_in [ST];

	logic [QW-1:0] num_d [ST];
	logic [DW-1:0] rem_d [ST];
	logic [QW-1:0] quo_d [ST];

	// Top dividend bits are below the divisor, so they seed the remainder
	always_comb begin
		num_in[0] = dividend[QW-1:0];
		rem_in[0] = DW'(dividend[PW-1:QW]);
		quo_in[0] = '0;
		dvs_in[0] = divisor;
		for (int k = 1; k < ST; k++) begin
			num_in[k] = num_s[k-1];
			rem_in[k] = rem_s[k-1];
			quo_in[k] = quo_s[k-1];
			dvs_in[k] = dvs_s[k-1];
		end
	end

	// Restoring division, a few quotient bits per stage
	always_comb begin
		logic [QW-1:0] n;
		logic [DW-1:0] r;
		logic [QW-1:0] q;
		logic [DW:0]   t;
		for (int k = 0; k < ST; k++) begin
			n = num_in[k];
			r = rem_in[k];
			q = quo_in[k];
			for (int j = 0; j < SPS; j++) begin
				if (k * SPS + j < QW) begin
					t = {r, n[QW-1]};
					if (t >= {1'b0, dvs_in[k]}) begin
						t = t - {1'b0, dvs_in[k]};
						q = {q[QW-2:0], 1'b1};
					end else begin
						q = {q[QW-2:0], 1'b0};
					end
					r = t[DW-1:0];
					n = {n[QW-2:0], 1'b0};
				end
			end
			num_d[k] = n;
			rem_d[k] = r;
			quo_d[k] = q;
		end
	end

	// Advance each stage when its enable is high
	always_ff @(posedge clk) begin
		for (int k = 0; k < ST; k++) begin
			if (en[k]) begin
				num_s[k] <= num_d[k];
				rem_s[k] <= rem_d[k];
				quo_s[k] <= quo_d[k];
				dvs_s[k] <= dvs_in[k];
			end
		end
	end

	assign quotient = quo_s[ST-1];

endmodule

// ----- sim/radial_lens_shading_gain_core_tb.sv -----
module radial_lens_shading_gain_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 1130;
	localparam int TAIL_CYCLES = 24;
	localparam int STALL_PHASE_LEN = 150;

	// Expected gain bytes in arrival order, with their own copy of the gain math
	class gain_scoreboard;
		logic [lsg_pkg::GAIN_W-1:0] expected_gains[$];
		int error_count;
		int gain_count;

		function new();
			error_count = 0;
			gain_count = 0;
		endfunction

		// Integer square root, floor
		function int floor_root(int sq);
			int root;
			root = 0;
			while ((root + 1) * (root + 1) <= sq) begin
				root++;
			end
			return root;
		endfunction

		function logic [lsg_pkg::GAIN_W-1:0] predict_gain(
				logic [lsg_pkg::COORD_W-1:0] x, logic [lsg_pkg::COORD_W-1:0] y,
				logic signed [lsg_pkg::BASE_W-1:0] base,
				logic [lsg_pkg::RADIUS_W-1:0] radius,
				logic signed [lsg_pkg::STRENGTH_W-1:0] strength);
			int dx;
			int dy;
			int radial_dist;
			int span;
			int boost;
			int sum;
			dx = int'(x) - lsg_pkg::GRID_WIDTH_DEF / 2;
			dy = int'(y) - lsg_pkg::GRID_HEIGHT_DEF / 2;
			radial_dist = floor_root(dx * dx + dy * dy);
			// Boost off: pass the low byte of the base, no clamp
			if (radius == '0) begin
				return base[lsg_pkg::GAIN_W-1:0];
			end
			span = int'(radius) - radial_dist;
			if (span < 0) begin
				span = 0;
			end
			// Division truncates toward zero, as the signed int operator does
			boost = (span * int'(strength)) / int'(radius);
			sum = int'(base) + boost;
			if (sum < 0) begin
				sum = 0;
			end
			if (sum > lsg_pkg::GAIN_MAX) begin
				sum = lsg_pkg::GAIN_MAX;
			end
			return sum[lsg_pkg::GAIN_W-1:0];
		endfunction

		function void note_cell(
				logic [lsg_pkg::COORD_W-1:0] x, logic [lsg_pkg::COORD_W-1:0] y,
				logic signed [lsg_pkg::BASE_W-1:0] base,
				logic [lsg_pkg::RADIUS_W-1:0] radius,
				logic signed [lsg_pkg::STRENGTH_W-1:0] strength);
			expected_gains.push_back(predict_gain(x, y, base, radius, strength));
		endfunction

		function void check_gain(logic [lsg_pkg::GAIN_W-1:0] actual);
			logic [lsg_pkg::GAIN_W-1:0] want;
			gain_count++;
			if (expected_gains.size() == 0) begin
				error_count++;
				if (error_count <= 10) begin
					$display("unexpected gain item %0d: got %0d", gain_count, actual);
				end
				return;
			end
			want = expected_gains[0];
			expected_gains.delete(0);
			if (actual !== want) begin
				error_count++;
				if (error_count <= 10) begin
					$display("gain_value error at item %0d: expected %0d, got %0d",
						gain_count, want, actual);
				end
			end
		endfunction

		function int pending();
			return expected_gains.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cell_valid = 1'b0;
	logic cell_ready;
	logic [lsg_pkg::COORD_W-1:0] cell_x = '0;
	logic [lsg_pkg::COORD_W-1:0] cell_y = '0;
	logic signed [lsg_pkg::BASE_W-1:0] channel_base = '0;
	logic [lsg_pkg::RADIUS_W-1:0] falloff_radius = '0;
	logic signed [lsg_pkg::STRENGTH_W-1:0] boost_strength = '0;
	logic gain_valid;
	logic gain_ready = 1'b0;
	logic [lsg_pkg::GAIN_W-1:0] gain_value;

	gain_scoreboard sb = new();

	int stall_phase_cnt = 0;
	int stall_mode = 0;

	radial_lens_shading_gain_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cell_valid(cell_valid),
		.cell_ready(cell_ready),
		.cell_x(cell_x),
		.cell_y(cell_y),
		.channel_base(channel_base),
		.falloff_radius(falloff_radius),
		.boost_strength(boost_strength),
		.gain_valid(gain_valid),
		.gain_ready(gain_ready),
		.gain_value(gain_value)
	);

	always #5 clk = ~clk;

	// Stall the output side; pick a new pattern every phase
	always @(posedge clk) begin
		if (stall_phase_cnt == 0) begin
			stall_mode = $urandom_range(0, 3);
		end
		stall_phase_cnt = (stall_phase_cnt + 1) % STALL_PHASE_LEN;
		case (stall_mode)
			0: gain_ready <= 1'b1;
			1: gain_ready <= ($urandom_range(0, 3) != 0);
			2: gain_ready <= ($urandom_range(0, 3) == 0);
			default: gain_ready <= (stall_phase_cnt % 8 < 5);
		endcase
	end

	// Record each accepted cell
	always @(posedge clk) begin
		if (arst_n && cell_valid && cell_ready) begin
			sb.note_cell(cell_x, cell_y, channel_base, falloff_radius, boost_strength);
		end
	end

	// Check each accepted gain
	always @(posedge clk) begin
		if (arst_n && gain_valid && gain_ready) begin
			sb.check_gain(gain_value);
		end
	end

	// Present one cell and hold it until accepted
	task automatic send_cell(
			logic [lsg_pkg::COORD_W-1:0] x, logic [lsg_pkg::COORD_W-1:0] y,
			logic signed [lsg_pkg::BASE_W-1:0] base,
			logic [lsg_pkg::RADIUS_W-1:0] radius,
			logic signed [lsg_pkg::STRENGTH_W-1:0] strength);
		cell_valid <= 1'b1;
		cell_x <= x;
		cell_y <= y;
		channel_base <= base;
		falloff_radius <= radius;
		boost_strength <= strength;
		do begin
			@(posedge clk);
		end while (!(cell_valid && cell_ready));
	endtask

	// Mostly in-grid cells, half of the bases moderate, with full-range values mixed in
	task automatic send_random_cell();
		logic [lsg_pkg::COORD_W-1:0] x;
		logic [lsg_pkg::COORD_W-1:0] y;
		logic signed [lsg_pkg::BASE_W-1:0] base;
		logic [lsg_pkg::RADIUS_W-1:0] radius;
		logic signed [lsg_pkg::STRENGTH_W-1:0] strength;
		x = ($urandom_range(0, 4) == 0) ? lsg_pkg::COORD_W'($urandom_range(0, 63))
			: lsg_pkg::COORD_W'($urandom_range(0, lsg_pkg::GRID_WIDTH_DEF - 1));
		y = ($urandom_range(0, 4) == 0) ? lsg_pkg::COORD_W'($urandom_range(0, 63))
			: lsg_pkg::COORD_W'($urandom_range(0, lsg_pkg::GRID_HEIGHT_DEF - 1));
		if ($urandom_range(0, 1) == 0) begin
			base = lsg_pkg::BASE_W'($urandom_range(0, 2047));
		end else begin
			base = lsg_pkg::BASE_W'(int'($urandom_range(0, 352)) - 48);
		end
		case ($urandom_range(0, 7))
			0: radius = '0;
			1, 2, 3: radius = lsg_pkg::RADIUS_W'($urandom_range(1, 48));
			default: radius = lsg_pkg::RADIUS_W'($urandom_range(0, 255));
		endcase
		strength = ($urandom_range(0, 9) == 0) ? '0
			: lsg_pkg::STRENGTH_W'($urandom_range(0, 8191));
		send_cell(x, y, base, radius, strength);
	endtask

	// Drop valid for a number of cycles
	task automatic pause_sender(int cycles);
		if (cycles == 0) begin
			return;
		end
		cell_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Drop valid, let the last accepted cell be recorded, then wait for every gain
	task automatic wait_for_drain();
		cell_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
	endtask

	initial begin
		int sent;
		int burst;
		int i;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed cells: field extremes and the corner cases of the gain math
		send_cell(26, 19, 0, 255, 4095);
		send_cell(26, 19, 0, 255, -4096);
		send_cell(0, 0, 1023, 0, 4095);
		send_cell(63, 63, -1024, 0, -4096);
		send_cell(5, 7, -1, 0, 100);
		send_cell(40, 2, 300, 0, -1);
		pause_sender(3);
		send_cell(0, 0, 100, 1, 4095);
		send_cell(0, 0, -1024, 5, 4095);
		send_cell(0, 0, 1023, 5, -4096);
		send_cell(63, 0, 32, 255, 2000);
		send_cell(0, 63, 200, 200, -3000);
		send_cell(26, 19, 50, 1, -33);
		send_cell(27, 19, 128, 3, -100);
		pause_sender(1);
		send_cell(30, 22, 0, 7, 100);
		send_cell(26, 63, 90, 44, 4095);
		send_cell(26, 0, -1024, 20, 4095);
		send_cell(51, 38, 1023, 255, 4095);
		send_cell(26, 19, 255, 255, 0);
		send_cell(26, 19, -200, 128, 4095);
		send_cell(10, 30, 1023, 255, -4096);
		send_cell(26, 19, 128, 0, -4096);
		send_cell(0, 0, 256, 255, -1);
		wait_for_drain();

		// Random cells in bursts, with one full drain halfway
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 40);
			for (i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
				send_random_cell();
				sent++;
				if (sent == RANDOM_ITEMS / 2) begin
					wait_for_drain();
				end
			end
			pause_sender(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6));
		end

		wait_for_drain();
		pause_sender(TAIL_CYCLES);
		if (sb.error_count == 0 && sb.pending() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Hard stop for a hung handshake
	initial begin
		#2_000_000ns;
		$display("Mismatches found");
		$finish;
	end

endmodule

// ----- radial_lens_shading_gain_core.f -----
sv/lsg_pkg.sv
sv/lsg_isqrt_pipe.sv
sv/lsg_div_pipe.sv
sv/radial_lens_shading_gain_core.sv
sim/radial_lens_shading_gain_core_tb.sv
